[rtl/core/tai_pkg.sv]
// ----------------------------------------------------------------------------
// tai_pkg: shared types and constants of the ascii trie block
// Sizes of the node table and link memory, memory request structs, fsm states.
// ----------------------------------------------------------------------------
package tai_pkg;

  // table sizing
  localparam int MAX_NODES = 1024;
  localparam int ALPHABET  = 128;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int USED_W    = $clog2(MAX_NODES + 1);
  localparam int CH_W      = $clog2(ALPHABET);
  localparam int SLOT_W    = NODE_W + CH_W;
  localparam int LINK_DEPTH = MAX_NODES * (2 ** CH_W);

  // key and value widths
  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;

  // one node table entry: slot of the edge that created it, and its value
  typedef struct packed {
    logic [SLOT_W-1:0]  parent;
    logic [VALUE_W-1:0] value;
  } node_ent_t;

  // request to the link memory
  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
    logic [NODE_W-1:0] wdata;
  } link_req_t;

  // request to the node memory
  typedef struct packed {
    logic              we;
    logic              re;
    logic [NODE_W-1:0] addr;
    node_ent_t         wdata;
  } node_req_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINK,
    ST_CHECK,
    ST_TERM,
    ST_FAIL
  } state_e;

endpackage

[rtl/core/ascii_trie_insert_lookup.sv]
// ----------------------------------------------------------------------------
// ascii_trie_insert_lookup: 128-way trie insert and lookup
// Keys arrive one character per word; the zero character ends the key and
// returns one result word.
//
//   channel   dir   tdata                  tuser
//   s_axis    in    character, value       func (1 insert, 0 lookup)
//   m_axis    out   found_value            insert_ok
//
// A key character reads the link memory and, for a link below the node fill
// count, then reads node memory to check the back pointer. A terminator reads
// node memory, then stores or fetches once the output word is free to load.
// A character ignored after a failure leaves the sequencer idle. Reset is
// immediate: no clearing pass, stale links are rejected by the back pointer
// and the node fill count.
// ----------------------------------------------------------------------------
module ascii_trie_insert_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [7:0] character, [39:8] stored_value
  input  logic        s_axis_tuser,  // [0] func
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] found_value
  output logic        m_axis_tuser   // [0] insert_ok
);

  tai_pkg::link_req_t         link_req;
  logic [tai_pkg::NODE_W-1:0] link_rdata;
  tai_pkg::node_req_t         node_req;
  tai_pkg::node_ent_t         node_rdata;

  // sequencer
  tai_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .func_i         (s_axis_tuser),
    .character_i    (s_axis_tdata[7:0]),
    .stored_value_i (s_axis_tdata[39:8]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .insert_ok_o    (m_axis_tuser),
    .found_value_o  (m_axis_tdata),
    .link_req_o     (link_req),
    .link_rdata_i   (link_rdata),
    .node_req_o     (node_req),
    .node_rdata_i   (node_rdata)
  );

  // child links
  tai_link_mem u_link_mem (
    .clk_i   (clk_i),
    .req_i   (link_req),
    .rdata_o (link_rdata)
  );

  // node table
  tai_node_mem u_node_mem (
    .clk_i   (clk_i),
    .req_i   (node_req),
    .rdata_o (node_rdata)
  );

endmodule

[rtl/core/tai_link_mem.sv]
// ----------------------------------------------------------------------------
// tai_link_mem: child link memory
// One entry per node and character, holding the child node index.
// Synchronous, one port, read data registered and held between reads.
// ----------------------------------------------------------------------------
module tai_link_mem (
  input  logic                      clk_i,
  input  tai_pkg::link_req_t        req_i,
  output logic [tai_pkg::NODE_W-1:0] rdata_o
);

  // contents after power-up are arbitrary, stale entries are screened by the
  // sequencer, so the array holds two-state bits
  bit [tai_pkg::NODE_W-1:0] mem [tai_pkg::LINK_DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.addr];
    end
  end

endmodule

[rtl/core/tai_node_mem.sv]
// ----------------------------------------------------------------------------
// tai_node_mem: node table memory
// One entry per node: back pointer to its creating edge and the stored value.
// Synchronous, one port, read data registered and held between reads.
// ----------------------------------------------------------------------------
module tai_node_mem (
  input  logic               clk_i,
  input  tai_pkg::node_req_t req_i,
  output tai_pkg::node_ent_t rdata_o
);

  tai_pkg::node_ent_t mem [tai_pkg::MAX_NODES];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.addr];
    end
  end

endmodule

[rtl/core/tai_ctrl.sv]
// ----------------------------------------------------------------------------
// tai_ctrl: trie walk sequencer
// Reads links, checks them against the node back pointer, allocates nodes,
// stores or fetches values at the terminator and holds the output word.
// ----------------------------------------------------------------------------
module tai_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input word
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [tai_pkg::CHAR_W-1:0]    character_i,
  input  logic [tai_pkg::VALUE_W-1:0]   stored_value_i,
  // output word
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          insert_ok_o,
  output logic [tai_pkg::VALUE_W-1:0]   found_value_o,
  // memories
  output tai_pkg::link_req_t            link_req_o,
  input  logic [tai_pkg::NODE_W-1:0]    link_rdata_i,
  output tai_pkg::node_req_t            node_req_o,
  input  tai_pkg::node_ent_t            node_rdata_i
);

  tai_pkg::state_e state_q, state_d;

  logic [tai_pkg::NODE_W-1:0]  cursor_q, cursor_d;
  logic [tai_pkg::USED_W-1:0]  used_q, used_d;
  logic                        failed_q, failed_d;
  logic                        root_set_q, root_set_d;
  logic                        func_q, func_d;
  logic [tai_pkg::VALUE_W-1:0] val_q, val_d;
  logic [tai_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_ok_q, out_ok_d;
  logic [tai_pkg::VALUE_W-1:0] out_val_q, out_val_d;

  logic accept;
  logic is_term;
  logic out_of_alpha;
  logic link_cand;
  logic parent_match;
  logic out_free;
  logic can_alloc;

  // shared decode
  assign in_ready_o   = (state_q == tai_pkg::ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign is_term      = (character_i == '0);
  assign out_of_alpha = ({1'b0, character_i} >= (tai_pkg::CHAR_W + 1)'(tai_pkg::ALPHABET));
  assign link_cand    = (link_rdata_i != '0) &&
                        ({1'b0, link_rdata_i} < used_q);
  assign parent_match = (node_rdata_i.parent == slot_q);
  assign out_free     = !out_valid_q || out_ready_i;
  assign can_alloc    = func_q && (used_q < tai_pkg::USED_W'(tai_pkg::MAX_NODES));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tai_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_term) begin
            state_d = failed_q ? tai_pkg::ST_FAIL : tai_pkg::ST_TERM;
          end else if (!failed_q && !out_of_alpha) begin
            state_d = tai_pkg::ST_LINK;
          end
        end
      end
      tai_pkg::ST_LINK: begin
        state_d = link_cand ? tai_pkg::ST_CHECK : tai_pkg::ST_IDLE;
      end
      tai_pkg::ST_CHECK: begin
        state_d = tai_pkg::ST_IDLE;
      end
      tai_pkg::ST_TERM, tai_pkg::ST_FAIL: begin
        if (out_free) begin
          state_d = tai_pkg::ST_IDLE;
        end
      end
      default: state_d = tai_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    logic miss;
    logic load;
    miss        = 1'b0;
    load        = 1'b0;
    cursor_d    = cursor_q;
    used_d      = used_q;
    failed_d    = failed_q;
    root_set_d  = root_set_q;
    func_d      = func_q;
    val_d       = val_q;
    slot_d      = slot_q;
    out_ok_d    = out_ok_q;
    out_val_d   = out_val_q;
    link_req_o  = '0;
    node_req_o  = '0;

    unique case (state_q)
      tai_pkg::ST_IDLE: begin
        if (accept) begin
          func_d = func_i;
          val_d  = stored_value_i;
          if (is_term) begin
            if (!failed_q) begin
              node_req_o.re   = 1'b1;
              node_req_o.addr = cursor_q;
            end
          end else if (!failed_q) begin
            if (out_of_alpha) begin
              failed_d = 1'b1;
            end else begin
              slot_d          = {cursor_q, character_i[tai_pkg::CH_W-1:0]};
              link_req_o.re   = 1'b1;
              link_req_o.addr = {cursor_q, character_i[tai_pkg::CH_W-1:0]};
            end
          end
        end
      end
      tai_pkg::ST_LINK: begin
        // a stale link is rejected by the node fill count here or by its node's back pointer
        if (link_cand) begin
          node_req_o.re   = 1'b1;
          node_req_o.addr = link_rdata_i;
        end else begin
          miss = 1'b1;
        end
      end
      tai_pkg::ST_CHECK: begin
        if (parent_match) begin
          cursor_d = link_rdata_i;
        end else begin
          miss = 1'b1;
        end
      end
      tai_pkg::ST_TERM: begin
        if (out_free) begin
          load = 1'b1;
          if (func_q) begin
            node_req_o.we           = 1'b1;
            node_req_o.addr         = cursor_q;
            node_req_o.wdata.parent = node_rdata_i.parent;
            node_req_o.wdata.value  = val_q;
            if (cursor_q == '0) begin
              root_set_d = 1'b1;
            end
            out_ok_d  = 1'b1;
            out_val_d = '0;
          end else begin
            out_ok_d  = 1'b0;
            // root value reads as zero until first stored
            out_val_d = ((cursor_q == '0) && !root_set_q) ? '0 : node_rdata_i.value;
          end
          cursor_d = '0;
          failed_d = 1'b0;
        end
      end
      tai_pkg::ST_FAIL: begin
        if (out_free) begin
          load      = 1'b1;
          out_ok_d  = 1'b0;
          out_val_d = '0;
          cursor_d  = '0;
          failed_d  = 1'b0;
        end
      end
      default: ;
    endcase

    // missing edge: allocate a fresh node or fail the key
    if (miss) begin
      if (can_alloc) begin
        link_req_o.we           = 1'b1;
        link_req_o.addr         = slot_q;
        link_req_o.wdata        = used_q[tai_pkg::NODE_W-1:0];
        node_req_o.we           = 1'b1;
        node_req_o.addr         = used_q[tai_pkg::NODE_W-1:0];
        node_req_o.wdata.parent = slot_q;
        node_req_o.wdata.value  = '0;
        cursor_d                = used_q[tai_pkg::NODE_W-1:0];
        used_d                  = used_q + 1'b1;
      end else begin
        failed_d = 1'b1;
      end
    end

    out_valid_d = load || (out_valid_q && !out_ready_i);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tai_pkg::ST_IDLE;
      cursor_q    <= '0;
      used_q      <= tai_pkg::USED_W'(1);
      failed_q    <= 1'b0;
      root_set_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      used_q      <= used_d;
      failed_q    <= failed_d;
      root_set_q  <= root_set_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    val_q     <= val_d;
    slot_q    <= slot_d;
    out_ok_q  <= out_ok_d;
    out_val_q <= out_val_d;
  end

  assign out_valid_o   = out_valid_q;
  assign insert_ok_o   = out_ok_q;
  assign found_value_o = out_val_q;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ascii trie insert and lookup block
// Drives keys one character word at a time, predicts each result word with a
// local copy of the trie, and compares every result field in order. A short
// table of directed words comes first, then random keys over four idling
// phases until the node table has been filled and overflowed.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          ITEMS       = 1500;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          END_CYCLES  = 20;
  localparam int          KEY_MAX     = 48;
  localparam int          KEY_POOL    = 64;
  localparam int          DIR_ROWS    = 25;
  localparam bit [7:0]    KEY_END     = 8'h00;

  typedef enum bit {
    FN_LOOKUP = 1'b0,
    FN_INSERT = 1'b1
  } func_e;

  typedef struct packed {
    bit        insert_ok;
    bit [31:0] found_value;
  } trie_answer_t;

  // answer typed into the directed table, or left to the trie copy
  typedef struct packed {
    bit           typed;
    trie_answer_t answer;
  } known_answer_t;

  typedef struct {
    func_e        func;
    bit [7:0]     ch;
    bit [31:0]    value;
    bit           typed;
    trie_answer_t answer;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [7:0] character, [39:8] stored_value
  logic        s_axis_tuser;   // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // [31:0] found_value
  logic        m_axis_tuser;   // [0] insert_ok

  ascii_trie_insert_lookup dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // local trie copy
  bit [tai_pkg::NODE_W-1:0] link_copy  [tai_pkg::LINK_DEPTH];
  bit [31:0]                value_copy [tai_pkg::MAX_NODES];
  int              nodes_taken   = 1;
  int              walk_node     = 0;
  bit              walk_failed   = 1'b0;
  bit              table_overrun = 1'b0;

  trie_answer_t  trie_answers[$];
  known_answer_t known_answers[$];
  int            items_done     = 0;
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            tx_idle_pct    = 0;
  int            rx_stall_pct   = 0;

  // key under construction and keys kept for reuse
  bit [7:0] key_buf [KEY_MAX];
  int       key_len;
  bit [7:0] saved_keys [KEY_POOL][KEY_MAX];
  int       saved_len [KEY_POOL];
  int       saved_count = 0;

  dir_row_t dir_rows [DIR_ROWS];

  // advance the trie copy by one accepted word
  function automatic void trie_walk(input func_e fn, input bit [7:0] ch,
                                    input bit [31:0] value, output bit has_answer,
                                    output trie_answer_t answer, output bit ignored);
    int                       slot;
    bit [tai_pkg::NODE_W-1:0] link;
    has_answer = 1'b0;
    answer     = '0;
    ignored    = 1'b0;
    if (ch == KEY_END) begin
      has_answer = 1'b1;
      if (!walk_failed) begin
        if (fn == FN_INSERT) begin
          value_copy[walk_node] = value;
          answer.insert_ok = 1'b1;
        end else begin
          answer.found_value = value_copy[walk_node];
        end
      end
      walk_node   = 0;
      walk_failed = 1'b0;
    end else if (walk_failed) begin
      ignored = 1'b1;
    end else if (ch >= tai_pkg::ALPHABET) begin
      walk_failed = 1'b1;
    end else begin
      slot = walk_node * tai_pkg::ALPHABET + ch;
      link = link_copy[slot];
      if (link == '0) begin
        if (fn != FN_INSERT) begin
          walk_failed = 1'b1;
        end else if (nodes_taken >= tai_pkg::MAX_NODES) begin
          walk_failed   = 1'b1;
          table_overrun = 1'b1;
        end else begin
          link = nodes_taken[tai_pkg::NODE_W-1:0];
          nodes_taken++;
          value_copy[link] = '0;
          link_copy[slot]  = link;
        end
      end
      if (!walk_failed) walk_node = int'(link);
    end
  endfunction

  // mostly random values, now and then an extreme
  function automatic bit [31:0] rand_value();
    case ($urandom_range(9))
      0: rand_value = 32'h7FFF_FFFF;
      1: rand_value = 32'h8000_0000;
      2: rand_value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: rand_value = $urandom;
    endcase
  endfunction

  // accepted words in, result words checked
  always @(posedge clk_i) begin
    bit            has_answer;
    bit            ignored;
    trie_answer_t  want;
    known_answer_t typed;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        trie_walk(func_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[39:8],
                  has_answer, want, ignored);
        if (has_answer) begin
          if (known_answers.size() != 0) begin
            typed = known_answers.pop_front();
            if (typed.typed) want = typed.answer;
          end
          trie_answers.push_back(want);
        end
        if (!ignored) items_done++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (trie_answers.size() == 0) begin
          $error("result word with no answer pending: insert_ok %0d found_value %0h",
                 m_axis_tuser, m_axis_tdata);
          mismatch_count++;
        end else begin
          want = trie_answers.pop_front();
          if (m_axis_tuser !== want.insert_ok) begin
            $error("insert_ok: expected %0d, got %0d", want.insert_ok, m_axis_tuser);
            mismatch_count++;
          end
          if (m_axis_tdata !== want.found_value) begin
            $error("found_value: expected %0h, got %0h", want.found_value, m_axis_tdata);
            mismatch_count++;
          end
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one word, after a random idle stretch
  task automatic send_word(input func_e fn, input bit [7:0] ch, input bit [31:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, ch};
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // key buffer plus terminator; mixed keys pick func per character
  task automatic send_key(input func_e fn, input bit mixed);
    func_e f;
    for (int i = 0; i <= key_len; i++) begin
      f = mixed ? ($urandom_range(1) ? FN_INSERT : FN_LOOKUP) : fn;
      if (i == key_len) send_word(f, KEY_END, rand_value());
      else              send_word(f, key_buf[i], $urandom);
    end
  endtask

  // sender holds off until every answer is back
  task automatic wait_answers();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (trie_answers.size() != 0);
  endtask

  // random keys until the item target, and the table overrun if asked
  task automatic run_random(input int target, input bit need_overrun);
    int    pick;
    int    n;
    func_e fn;
    bit    mixed;
    while (items_done < target || (need_overrun && !table_overrun)) begin
      pick  = $urandom_range(99);
      fn    = $urandom_range(1) ? FN_INSERT : FN_LOOKUP;
      mixed = ($urandom_range(9) == 0);
      if (items_done >= target) pick = 70;
      if (pick < 45 && saved_count > 0) begin
        // revisit a known key
        n       = $urandom_range(saved_count - 1);
        key_len = saved_len[n];
        for (int i = 0; i < key_len; i++) key_buf[i] = saved_keys[n][i];
        fn = ($urandom_range(9) < 4) ? FN_INSERT : FN_LOOKUP;
      end else if (pick < 65) begin
        // short keys over a few letters share prefixes
        key_len = $urandom_range(4);
        for (int i = 0; i < key_len; i++) key_buf[i] = 8'h61 + 8'($urandom_range(7));
      end else if (pick < 80) begin
        // long fresh insert, eats nodes
        key_len = $urandom_range(40, 8);
        for (int i = 0; i < key_len; i++) key_buf[i] = 8'($urandom_range(127, 1));
        fn    = FN_INSERT;
        mixed = 1'b0;
      end else if (pick < 90) begin
        // one character outside the alphabet
        key_len = $urandom_range(6, 1);
        for (int i = 0; i < key_len; i++) key_buf[i] = 8'($urandom_range(127, 1));
        key_buf[$urandom_range(key_len - 1)] = 8'($urandom_range(255, 128));
      end else begin
        // any non-zero byte
        key_len = $urandom_range(6, 1);
        for (int i = 0; i < key_len; i++) key_buf[i] = 8'($urandom_range(255, 1));
      end
      send_key(fn, mixed);
      if (fn == FN_INSERT && !mixed) begin
        if (saved_count < KEY_POOL) begin
          n = saved_count;
          saved_count++;
        end else begin
          n = $urandom_range(KEY_POOL - 1);
        end
        saved_len[n] = key_len;
        for (int i = 0; i < key_len; i++) saved_keys[n][i] = key_buf[i];
      end
    end
  endtask

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;

    // root value, single edge, alphabet limits, failures, partial insert,
    // mixed func
    dir_rows = '{
      '{FN_LOOKUP, KEY_END, 32'h1234_5678, 1'b1, '{1'b0, 32'h0}},
      '{FN_INSERT, KEY_END, 32'h7FFF_FFFF, 1'b1, '{1'b1, 32'h0}},
      '{FN_INSERT, 8'h61,   32'hFFFF_FFFF, 1'b0, '{1'b0, 32'h0}},
      '{FN_INSERT, KEY_END, 32'h8000_0000, 1'b1, '{1'b1, 32'h0}},
      '{FN_LOOKUP, 8'h61,   32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
      '{FN_LOOKUP, KEY_END, 32'h5555_5555, 1'b1, '{1'b0, 32'h8000_0000}},
      '{FN_LOOKUP, 8'h62,   32'hAAAA_AAAA, 1'b0, '{1'b0, 32'h0}},
      '{FN_LOOKUP, KEY_END, 32'h0000_0001, 1'b1, '{1'b0, 32'h0}},
      '{FN_INSERT, 8'h7F,   32'h0F0F_0F0F, 1'b0, '{1'b0, 32'h0}},
      '{FN_INSERT, 8'h01,   32'hF0F0_F0F0, 1'b0, '{1'b0, 32'h0}},
      '{FN_INSERT, KEY_END, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0}},
      '{FN_LOOKUP, 8'h7F,   32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
      '{FN_LOOKUP, 8'h01,   32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
      '{FN_LOOKUP, KEY_END, 32'h0000_0000, 1'b1, '{1'b0, 32'hFFFF_FFFF}},
      '{FN_INSERT, 8'h7A,   32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
      '{FN_INSERT, 8'h80,   32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
      '{FN_INSERT, 8'h78,   32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
      '{FN_INSERT, KEY_END, 32'h2468_ACE0, 1'b1, '{1'b0, 32'h0}},
      '{FN_LOOKUP, 8'h7A,   32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
      '{FN_LOOKUP, KEY_END, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
      '{FN_LOOKUP, 8'hFF,   32'hFFFF_FFFF, 1'b0, '{1'b0, 32'h0}},
      '{FN_LOOKUP, KEY_END, 32'h0000_0000, 1'b1, '{1'b0, 32'h0}},
      '{FN_LOOKUP, 8'h61,   32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
      '{FN_INSERT, 8'h71,   32'h0000_0000, 1'b0, '{1'b0, 32'h0}},
      '{FN_LOOKUP, KEY_END, 32'h0000_0000, 1'b0, '{1'b0, 32'h0}}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].ch == KEY_END) known_answers.push_back({dir_rows[r].typed,
                                                              dir_rows[r].answer});
      send_word(dir_rows[r].func, dir_rows[r].ch, dir_rows[r].value);
    end

    // random keys under each idling mix, draining between phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
        default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
      endcase
      wait_answers();
      run_random(ITEMS * (ph + 1) / 4, ph == 3);
    end

    wait_answers();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && trie_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
